// ===== design/sawfn_pkg.sv =====
// Shared types, constants and codes of the stop-and-wait forwarding node.
`timescale 1ns / 1ps
package sawfn_pkg;

  // Queue geometry and handle storage
  localparam int QUEUE_DEPTH = 16;
  localparam int HANDLE_BITS = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W      = $clog2(2 * QUEUE_DEPTH);
  localparam int HANDLE_W    = 16;
  localparam int STORE_W     = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

  // Routing threshold register
  localparam int              THR_W     = 17;
  localparam int              RND_W     = 16;
  localparam logic [THR_W-1:0] THR_RESET = 17'd32768;

  // Command queue between front and back
  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  // Result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_NAK  = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ACK_EMPTY = 3'd1;
  localparam logic [2:0] ST_BUSY      = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  // Incoming event codes
  typedef enum logic [1:0] {
    CMD_SOURCE = 2'd0,
    CMD_DATA   = 2'd1,
    CMD_ACK    = 2'd2,
    CMD_NAK    = 2'd3
  } cmd_code_t;

  // Classified operation handed to the back end
  typedef enum logic [1:0] {
    OP_ROUTE,
    OP_REPLY_NAK,
    OP_ACK_RX,
    OP_NAK_RX
  } op_t;

  typedef struct packed {
    op_t                op;
    logic               reply_ack;
    logic               reply_port;
    logic               port;
    logic [STORE_W-1:0] handle;
    logic [1:0]         busy;
  } cmd_t;

  typedef struct packed {
    logic                send_valid;
    logic                port;
    logic [1:0]          kind;
    logic [HANDLE_W-1:0] handle;
    logic [2:0]          status;
    logic                last;
  } res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } back_state_t;

endpackage

// ===== design/stop_and_wait_forwarding_node.sv =====
// Top level of the two-port stop-and-wait forwarding node.
`timescale 1ns / 1ps
// Usage:
//  - Input channel (in_valid / in_stall): one word per event - a local source
//    packet, a data packet from a neighbour, an ACK or a NAK, with its random
//    routing word and the busy flags of both output channels.
//  - Result channel (out_valid / out_stall): one word per transmission or
//    status. A correct data packet gives two words (ACK, then the routing
//    outcome); every other event gives one. out_last marks the final word.
//  - cfg_wr_en / cfg_wr_data write the routing threshold; write it only while
//    the node is idle.
//  - An event passes the command queue, then the back end's dequeue and
//    execute steps, into the result register. The ACK of a routed data
//    packet takes one more execute step, and a queued head adds a read of
//    the packet store, whose read data is registered. The back end takes
//    no new event until it is done with the last.
//  - A two-word command queue decouples the front end from the back end, so
//    events keep being taken while a result waits in the output register.
//  - Reset empties both packet queues and the command queue and loads the
//    threshold with one half. The packet store itself is not cleared.
//  - When the receiver stalls, the result word holds, the back end stops
//    and, once the command queue fills, in_stall rises.
module stop_and_wait_forwarding_node (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [sawfn_pkg::THR_W-1:0]    cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_cmd,
  input  logic                           in_arrival_port,
  input  logic                           in_bit_error,
  input  logic [sawfn_pkg::HANDLE_W-1:0] in_packet_handle,
  input  logic [sawfn_pkg::RND_W-1:0]    in_random_word,
  input  logic [1:0]                     in_channel_busy,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_send_valid,
  output logic                           out_port,
  output logic [1:0]                     out_kind,
  output logic [sawfn_pkg::HANDLE_W-1:0] out_handle,
  output logic [2:0]                     out_status,
  output logic                           out_last
);

  logic            q_full, q_push, q_pop, q_empty;
  sawfn_pkg::cmd_t push_cmd, pop_cmd;
  sawfn_pkg::res_t res;

  // Accept and classify events, route decision taken here
  sawfn_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_arrival_port  (in_arrival_port),
    .in_bit_error     (in_bit_error),
    .in_packet_handle (in_packet_handle),
    .in_random_word   (in_random_word),
    .in_channel_busy  (in_channel_busy),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (push_cmd)
  );

  // Hold classified commands until the back end is free
  sawfn_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  // Advance the port queues and drive the result register
  sawfn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_send_valid = res.send_valid;
  assign out_port       = res.port;
  assign out_kind       = res.kind;
  assign out_handle     = res.handle;
  assign out_status     = res.status;
  assign out_last       = res.last;

  // Only the ACK of a routed data packet is a non-final word
  a_nonlast_is_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_send_valid && out_kind == sawfn_pkg::KIND_ACK))
    else $error("non-final result word is not an ACK");

  // An ACK or NAK word always transmits and carries status ok
  a_reply_sends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != sawfn_pkg::KIND_DATA)
      |-> (out_send_valid && out_status == sawfn_pkg::ST_OK))
    else $error("reply word does not transmit");

  // A word that sends nothing carries no handle
  a_idle_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_send_valid) |-> (out_handle == '0 && out_kind == sawfn_pkg::KIND_DATA))
    else $error("non-transmitting word carries a handle or kind");

  // A non-final ACK is always followed by the final word of the same event
  a_ack_then_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=> (!out_valid || out_last))
    else $error("two non-final words in a row");

endmodule

// ===== design/sawfn_front.sv =====
// Front end: threshold register, word acceptance and event classification.
`timescale 1ns / 1ps
module sawfn_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [sawfn_pkg::THR_W-1:0]   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_cmd,
  input  logic                          in_arrival_port,
  input  logic                          in_bit_error,
  input  logic [sawfn_pkg::HANDLE_W-1:0] in_packet_handle,
  input  logic [sawfn_pkg::RND_W-1:0]   in_random_word,
  input  logic [1:0]                    in_channel_busy,
  input  logic                          q_full,
  output logic                          q_push,
  output sawfn_pkg::cmd_t               q_cmd
);

  logic [sawfn_pkg::THR_W-1:0] thr_r;
  logic                        route_port;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= sawfn_pkg::THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  assign in_stall   = q_full;
  assign q_push     = in_valid && !q_full;
  // Port 0 when the random word lies below the threshold
  assign route_port = ({1'b0, in_random_word} < thr_r) ? 1'b0 : 1'b1;

  always_comb begin
    q_cmd            = '0;
    q_cmd.op         = sawfn_pkg::OP_ROUTE;
    q_cmd.reply_ack  = 1'b0;
    q_cmd.reply_port = in_arrival_port;
    q_cmd.port       = route_port;
    q_cmd.handle     = in_packet_handle[sawfn_pkg::STORE_W-1:0];
    q_cmd.busy       = in_channel_busy;
    unique case (sawfn_pkg::cmd_code_t'(in_cmd))
      sawfn_pkg::CMD_SOURCE: begin
        q_cmd.op = sawfn_pkg::OP_ROUTE;
      end
      sawfn_pkg::CMD_DATA: begin
        if (in_bit_error) begin
          q_cmd.op = sawfn_pkg::OP_REPLY_NAK;
        end else begin
          q_cmd.reply_ack = 1'b1;
        end
      end
      sawfn_pkg::CMD_ACK: begin
        q_cmd.op   = sawfn_pkg::OP_ACK_RX;
        q_cmd.port = in_arrival_port;
      end
      sawfn_pkg::CMD_NAK: begin
        q_cmd.op   = sawfn_pkg::OP_NAK_RX;
        q_cmd.port = in_arrival_port;
      end
      default: begin
        q_cmd.op = sawfn_pkg::OP_ROUTE;
      end
    endcase
  end

endmodule

// ===== design/sawfn_cmdq.sv =====
// Short command queue between front and back ends.
`timescale 1ns / 1ps
module sawfn_cmdq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sawfn_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output sawfn_pkg::cmd_t pop_cmd,
  output logic            empty
);

  sawfn_pkg::cmd_t                  entry_r [sawfn_pkg::CQ_DEPTH];
  logic [sawfn_pkg::CQ_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [sawfn_pkg::CQ_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [sawfn_pkg::CQ_CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == sawfn_pkg::CQ_CNT_W'(sawfn_pkg::CQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_cmd = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == sawfn_pkg::CQ_PTR_W'(sawfn_pkg::CQ_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == sawfn_pkg::CQ_PTR_W'(sawfn_pkg::CQ_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== design/sawfn_back.sv =====
// Back end: per-port packet queues, replies and transmissions, result register.
`timescale 1ns / 1ps
module sawfn_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  sawfn_pkg::cmd_t q_cmd,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output sawfn_pkg::res_t out_res
);

  sawfn_pkg::back_state_t            state_r, state_nxt;
  sawfn_pkg::cmd_t                   cmd_r, cmd_nxt;
  logic [sawfn_pkg::IDX_W-1:0]       head_r [2];
  logic [sawfn_pkg::IDX_W-1:0]       head_nxt [2];
  logic [sawfn_pkg::CNT_W-1:0]       cnt_r [2];
  logic [sawfn_pkg::CNT_W-1:0]       cnt_nxt [2];
  logic                              out_valid_r, out_valid_nxt;
  sawfn_pkg::res_t                   res_r, res_nxt;

  logic [sawfn_pkg::STORE_W-1:0]     queue_store_r [2 * sawfn_pkg::QUEUE_DEPTH];
  logic [sawfn_pkg::STORE_W-1:0]     rd_data_r;
  logic                              wr_en, rd_en;
  logic [sawfn_pkg::ADDR_W-1:0]      wr_addr, rd_addr;

  logic                              p;
  logic [sawfn_pkg::IDX_W-1:0]       head_p, head_inc, tail_idx;
  logic [sawfn_pkg::CNT_W-1:0]       cnt_p;
  logic [sawfn_pkg::ADDR_W-1:0]      tail_sum;
  logic                              busy_p, slot_free, emit;
  sawfn_pkg::res_t                   er;

  function automatic logic [sawfn_pkg::ADDR_W-1:0] store_addr(
    input logic port, input logic [sawfn_pkg::IDX_W-1:0] idx);
    logic [sawfn_pkg::ADDR_W-1:0] base;
    base = port ? sawfn_pkg::ADDR_W'(sawfn_pkg::QUEUE_DEPTH) : '0;
    return base + sawfn_pkg::ADDR_W'(idx);
  endfunction

  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign slot_free = !out_valid_r || !out_stall;

  assign p        = cmd_r.port;
  assign head_p   = head_r[p];
  assign cnt_p    = cnt_r[p];
  assign busy_p   = cmd_r.busy[p];
  assign head_inc = (head_p == sawfn_pkg::IDX_W'(sawfn_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : head_p + 1'b1;
  assign tail_sum = sawfn_pkg::ADDR_W'(head_p) + sawfn_pkg::ADDR_W'(cnt_p);
  assign tail_idx = (tail_sum >= sawfn_pkg::ADDR_W'(sawfn_pkg::QUEUE_DEPTH)) ?
                    sawfn_pkg::IDX_W'(tail_sum - sawfn_pkg::ADDR_W'(sawfn_pkg::QUEUE_DEPTH)) :
                    sawfn_pkg::IDX_W'(tail_sum);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    head_nxt[0]   = head_r[0];
    head_nxt[1]   = head_r[1];
    cnt_nxt[0]    = cnt_r[0];
    cnt_nxt[1]    = cnt_r[1];
    out_valid_nxt = out_valid_r && out_stall;
    res_nxt       = res_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    emit          = 1'b0;
    er            = '0;
    er.port       = p;
    er.last       = 1'b1;

    unique case (state_r)
      sawfn_pkg::S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_cmd;
          state_nxt = sawfn_pkg::S_EXEC;
        end
      end
      sawfn_pkg::S_EXEC: begin
        if (slot_free) begin
          emit      = 1'b1;
          state_nxt = sawfn_pkg::S_IDLE;
          unique case (cmd_r.op)
            sawfn_pkg::OP_REPLY_NAK: begin
              er.send_valid = 1'b1;
              er.port       = cmd_r.reply_port;
              er.kind       = sawfn_pkg::KIND_NAK;
            end
            sawfn_pkg::OP_ROUTE: begin
              if (cmd_r.reply_ack) begin
                // Acknowledge first, route on the next pass
                er.send_valid     = 1'b1;
                er.port           = cmd_r.reply_port;
                er.kind           = sawfn_pkg::KIND_ACK;
                er.last           = 1'b0;
                cmd_nxt.reply_ack = 1'b0;
                state_nxt         = sawfn_pkg::S_EXEC;
              end else if (cnt_p == sawfn_pkg::CNT_W'(sawfn_pkg::QUEUE_DEPTH)) begin
                er.status = sawfn_pkg::ST_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = store_addr(p, tail_idx);
                cnt_nxt[p] = cnt_p + 1'b1;
                if (cnt_p == '0) begin
                  // Empty queue: the new packet is the head, send it straight unless its channel is busy
                  if (busy_p) begin
                    er.status = sawfn_pkg::ST_BUSY;
                  end else begin
                    er.send_valid = 1'b1;
                    er.handle     = sawfn_pkg::HANDLE_W'(cmd_r.handle);
                  end
                end
              end
            end
            sawfn_pkg::OP_ACK_RX: begin
              if (cnt_p == '0) begin
                er.status = sawfn_pkg::ST_ACK_EMPTY;
              end else begin
                head_nxt[p] = head_inc;
                cnt_nxt[p]  = cnt_p - 1'b1;
                if (cnt_p == sawfn_pkg::CNT_W'(1)) begin
                  er.status = sawfn_pkg::ST_EMPTY;
                end else if (busy_p) begin
                  er.status = sawfn_pkg::ST_BUSY;
                end else begin
                  emit      = 1'b0;
                  rd_en     = 1'b1;
                  rd_addr   = store_addr(p, head_inc);
                  state_nxt = sawfn_pkg::S_READ;
                end
              end
            end
            sawfn_pkg::OP_NAK_RX: begin
              if (cnt_p == '0) begin
                er.status = sawfn_pkg::ST_EMPTY;
              end else if (busy_p) begin
                er.status = sawfn_pkg::ST_BUSY;
              end else begin
                emit      = 1'b0;
                rd_en     = 1'b1;
                rd_addr   = store_addr(p, head_p);
                state_nxt = sawfn_pkg::S_READ;
              end
            end
            default: begin
              er.status = sawfn_pkg::ST_OK;
            end
          endcase
        end
      end
      sawfn_pkg::S_READ: begin
        if (slot_free) begin
          emit          = 1'b1;
          er.send_valid = 1'b1;
          er.handle     = sawfn_pkg::HANDLE_W'(rd_data_r);
          state_nxt     = sawfn_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sawfn_pkg::S_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
      res_nxt       = er;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sawfn_pkg::S_IDLE;
      head_r[0]   <= '0;
      head_r[1]   <= '0;
      cnt_r[0]    <= '0;
      cnt_r[1]    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r[0]   <= head_nxt[0];
      head_r[1]   <= head_nxt[1];
      cnt_r[0]    <= cnt_nxt[0];
      cnt_r[1]    <= cnt_nxt[1];
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      queue_store_r[wr_addr] <= cmd_r.handle;
    end
    if (rd_en) begin
      rd_data_r <= queue_store_r[rd_addr];
    end
  end

endmodule
